// ===== design/lesf_pkg.sv =====
// ----------------------------------------------------------------------------
// lesf_pkg
// Types and register indexes shared by the largest empty square finder.
// ----------------------------------------------------------------------------
`default_nettype none

package lesf_pkg;

	typedef logic [10:0] side_t;
	typedef logic [12:0] row_t;
	typedef logic [7:0]  byte_t;

	typedef logic [0:0] cfg_idx_t;
	typedef logic [10:0] cfg_data_t;

	localparam cfg_idx_t REG_EMPTY_CHAR = 1'd0;
	localparam cfg_idx_t REG_ROW_WIDTH  = 1'd1;

	localparam byte_t EMPTY_CHAR_RST = 8'd46;
	localparam side_t ROW_WIDTH_RST  = 11'd5;

	typedef struct packed {
		byte_t cell_byte;
		logic  first_cell;
	} in_item_t;

	typedef struct packed {
		side_t cell_side;
		side_t best_side;
		row_t  best_row;
		side_t best_column;
	} out_item_t;

endpackage

`default_nettype wire

// ===== design/lesf_line_buf.sv =====
// ----------------------------------------------------------------------------
// lesf_line_buf
// One-row buffer of square sides, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lesf_line_buf #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10,
	parameter int DATA_W = 11
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== design/lesf_pos.sv =====
// ----------------------------------------------------------------------------
// lesf_pos
// Column and row counters: gives the position of the cell being taken in.
// ----------------------------------------------------------------------------
`default_nettype none

module lesf_pos #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_ROWS  = 4096,
	parameter int COL_W     = 10,
	parameter int ROW_W     = 13
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic              first_cell,
	input  wire lesf_pkg::side_t   row_width,
	output logic      [COL_W-1:0]  col,
	output logic      [ROW_W-1:0]  row
);

	localparam int COLP_W = COL_W + 1;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [31:0]       w_wide;
	logic [COLP_W-1:0] w_eff;
	logic [COL_W-1:0]  c0;
	logic [ROW_W-1:0]  r0;
	logic [ROW_W-1:0]  r0_inc;
	logic [ROW_W-1:0]  r1_inc;
	logic              pre_wrap;
	logic [COLP_W-1:0] col_next;
	logic              post_wrap;

	always_comb begin
		w_wide = 32'(row_width);
		if (w_wide == 32'd0) begin
			w_wide = 32'd1;
		end else if (w_wide > 32'(MAX_WIDTH)) begin
			w_wide = 32'(MAX_WIDTH);
		end
	end

	assign w_eff = COLP_W'(w_wide);

	assign c0       = first_cell ? '0 : col_q;
	assign r0       = first_cell ? ROW_W'(1) : row_q;
	assign r0_inc   = (r0 < ROW_W'(MAX_ROWS)) ? r0 + ROW_W'(1) : r0;
	assign pre_wrap = {1'b0, c0} >= w_eff;

	// width shrink mid-grid starts a new row before the cell
	assign col = pre_wrap ? '0 : c0;
	assign row = pre_wrap ? r0_inc : r0;

	assign r1_inc    = (row < ROW_W'(MAX_ROWS)) ? row + ROW_W'(1) : row;
	assign col_next  = {1'b0, col} + COLP_W'(1);
	assign post_wrap = col_next >= w_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= ROW_W'(1);
		end else if (accept) begin
			if (post_wrap) begin
				col_q <= '0;
				row_q <= r1_inc;
			end else begin
				col_q <= col_next[COL_W-1:0];
				row_q <= row;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/largest_empty_square_finder.sv =====
// ----------------------------------------------------------------------------
// largest_empty_square_finder
// Maximal free square search over a byte grid streamed in row-major order.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | lesf_pkg::in_item_t
//   out     | output    | out_valid / out_ready | lesf_pkg::out_item_t
//   cfg     | input     | cfg_wr_en             | cfg_index, cfg_data
//
// One cell per cycle while the output is not stalled; a result passes the
// compute stage and the output register, then waits there for out_ready.
// The line buffer is read when a cell is taken in and written when its side
// leaves the compute stage; a one-cell row is served by forwarding.
// Reset clears counters, best square and handshake state; the line buffer
// needs no clearing, since the first row of a grid ignores what it reads.
// A stalled output holds the compute stage, which then holds the input.
// ----------------------------------------------------------------------------
`default_nettype none

module largest_empty_square_finder #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_ROWS  = 4096
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire lesf_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output lesf_pkg::out_item_t      out_data,
	input  wire logic                cfg_wr_en,
	input  wire lesf_pkg::cfg_idx_t  cfg_index,
	input  wire lesf_pkg::cfg_data_t cfg_data
);

	localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W  = $clog2(MAX_ROWS + 1);
	localparam int SIDE_W = $clog2(MAX_WIDTH + 1);
	localparam int SUM_W  = SIDE_W + 1;

	lesf_pkg::byte_t  empty_char_q;
	lesf_pkg::side_t  row_width_q;

	logic              in_xfer;
	logic              s1_adv;
	logic [COL_W-1:0]  col_cur;
	logic [ROW_W-1:0]  row_cur;

	logic              valid_s1;
	logic [COL_W-1:0]  col_s1;
	logic [ROW_W-1:0]  row_s1;
	logic              free_s1;
	logic              first_s1;
	logic              fwd_s1;
	logic [SIDE_W-1:0] fwd_side_s1;

	logic [SIDE_W-1:0] rd_side;
	logic [SIDE_W-1:0] up;
	logic [SIDE_W-1:0] left_q;
	logic [SIDE_W-1:0] upleft_q;
	logic [SIDE_W-1:0] min_a;
	logic [SIDE_W-1:0] min_b;
	logic [SUM_W-1:0]  sum;
	logic [SIDE_W-1:0] side;

	logic [SIDE_W-1:0] best_side_q;
	logic [ROW_W-1:0]  best_row_q;
	logic [SIDE_W-1:0] best_col_q;
	logic [SIDE_W-1:0] best_side_base;
	logic [ROW_W-1:0]  best_row_base;
	logic [SIDE_W-1:0] best_col_base;
	logic              better;
	logic [SIDE_W-1:0] best_side_new;
	logic [ROW_W-1:0]  best_row_new;
	logic [SIDE_W-1:0] best_col_new;

	logic                out_valid_q;
	lesf_pkg::out_item_t out_data_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_char_q <= lesf_pkg::EMPTY_CHAR_RST;
			row_width_q  <= lesf_pkg::ROW_WIDTH_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				lesf_pkg::REG_EMPTY_CHAR: empty_char_q <= cfg_data[7:0];
				lesf_pkg::REG_ROW_WIDTH:  row_width_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake
	assign s1_adv   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_adv;
	assign in_xfer  = in_valid && in_ready;

	lesf_pos #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_ROWS  (MAX_ROWS),
		.COL_W     (COL_W),
		.ROW_W     (ROW_W)
	) u_pos (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_xfer),
		.first_cell (in_data.first_cell),
		.row_width  (row_width_q),
		.col        (col_cur),
		.row        (row_cur)
	);

	lesf_line_buf #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (COL_W),
		.DATA_W (SIDE_W)
	) u_buf (
		.clk     (clk),
		.rd_en   (in_xfer),
		.rd_addr (col_cur),
		.rd_data (rd_side),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (side)
	);

	// compute stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			col_s1      <= col_cur;
			row_s1      <= row_cur;
			free_s1     <= (in_data.cell_byte == empty_char_q);
			first_s1    <= in_data.first_cell;
			// write to the same entry lands on this edge
			fwd_s1      <= s1_adv && (col_s1 == col_cur);
			fwd_side_s1 <= side;
		end
	end

	assign up    = fwd_s1 ? fwd_side_s1 : rd_side;
	assign min_a = (up < upleft_q) ? up : upleft_q;
	assign min_b = (min_a < left_q) ? min_a : left_q;
	assign sum   = {1'b0, min_b} + SUM_W'(1);

	always_comb begin
		if (!free_s1) begin
			side = '0;
		end else if (row_s1 == ROW_W'(1) || col_s1 == '0) begin
			side = SIDE_W'(1);
		end else if (sum > SUM_W'(MAX_WIDTH)) begin
			side = SIDE_W'(MAX_WIDTH);
		end else begin
			side = sum[SIDE_W-1:0];
		end
	end

	assign best_side_base = first_s1 ? '0 : best_side_q;
	assign best_row_base  = first_s1 ? '0 : best_row_q;
	assign best_col_base  = first_s1 ? '0 : best_col_q;
	assign better         = side > best_side_base;
	assign best_side_new  = better ? side : best_side_base;
	assign best_row_new   = better ? row_s1 : best_row_base;
	assign best_col_new   = better ? (SIDE_W'(col_s1) + SIDE_W'(1)) : best_col_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			upleft_q    <= '0;
			best_side_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
		end else if (s1_adv) begin
			left_q      <= side;
			upleft_q    <= up;
			best_side_q <= best_side_new;
			best_row_q  <= best_row_new;
			best_col_q  <= best_col_new;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q.cell_side   <= lesf_pkg::side_t'(side);
			out_data_q.best_side   <= lesf_pkg::side_t'(best_side_new);
			out_data_q.best_row    <= lesf_pkg::row_t'(best_row_new);
			out_data_q.best_column <= lesf_pkg::side_t'(best_col_new);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// ===== design/lesf_checker.sv =====
// ----------------------------------------------------------------------------
// lesf_checker
// Port-level checks for the largest empty square finder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module lesf_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire lesf_pkg::out_item_t out_data
);

	// stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// stalled result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

	// best square never smaller than the cell's own square
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.best_side >= out_data.cell_side)
		else $error("best side below cell side");

	// no best square means no position, and a best square has one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.best_side == '0) ==
			(out_data.best_row == '0 && out_data.best_column == '0)))
		else $error("best position inconsistent with best side");

endmodule

bind largest_empty_square_finder lesf_checker u_lesf_checker (.*);

`default_nettype wire

// ===== verif/tb_largest_empty_square_finder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_largest_empty_square_finder
// Streams byte grids through the square finder and scores every result
// against a cycle-free model of the maximal-square recurrence. Directed grids
// cover reset values, byte and width extremes, width changes inside a grid
// and ties. Random grids follow under four idling patterns.
// ----------------------------------------------------------------------------
module tb_largest_empty_square_finder;

	localparam int MAX_W = 1024;
	localparam int MAX_R = 4096;
	localparam lesf_pkg::byte_t FREE  = ".";
	localparam lesf_pkg::byte_t BLOCK = "#";

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	lesf_pkg::in_item_t  in_data;
	logic                out_valid;
	logic                out_ready;
	lesf_pkg::out_item_t out_data;
	logic                cfg_wr_en;
	lesf_pkg::cfg_idx_t  cfg_index;
	lesf_pkg::cfg_data_t cfg_data;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned error_count = 0;

	// model state
	int              empty_char_q = 46;
	int              row_width_q = 5;
	lesf_pkg::side_t side_buf [MAX_W] = '{default: '0};
	lesf_pkg::side_t left_q = '0;
	lesf_pkg::side_t upleft_q = '0;
	int              col_q = 0;
	int              row_q = 1;
	lesf_pkg::side_t best_side_q = '0;
	int              best_row_q = 0;
	int              best_col_q = 0;
	int              written_ext = 0;

	lesf_pkg::out_item_t expected_squares [$];

	largest_empty_square_finder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int eff_width(input int w);
		if (w == 0)
			return 1;
		if (w > MAX_W)
			return MAX_W;
		return w;
	endfunction

	function automatic void next_line();
		col_q = 0;
		if (row_q < MAX_R)
			row_q++;
	endfunction

	function automatic lesf_pkg::out_item_t compute_square(input lesf_pkg::in_item_t item);
		int                  w;
		int                  c;
		lesf_pkg::side_t     up;
		lesf_pkg::side_t     m;
		int                  side;
		lesf_pkg::out_item_t r;
		w = eff_width(row_width_q);
		if (item.first_cell) begin
			col_q = 0;
			row_q = 1;
			best_side_q = '0;
			best_row_q = 0;
			best_col_q = 0;
			left_q = '0;
			upleft_q = '0;
		end
		if (col_q >= w)
			next_line();
		c = col_q;
		up = side_buf[c];
		if (int'(item.cell_byte) != empty_char_q)
			side = 0;
		else if (row_q == 1 || c == 0)
			side = 1;
		else begin
			m = (up < upleft_q) ? up : upleft_q;
			if (left_q < m)
				m = left_q;
			side = int'(m) + 1;
		end
		if (side > MAX_W)
			side = MAX_W;
		upleft_q = up;
		left_q = lesf_pkg::side_t'(side);
		side_buf[c] = lesf_pkg::side_t'(side);
		if (c + 1 > written_ext)
			written_ext = c + 1;
		if (side > int'(best_side_q)) begin
			best_side_q = lesf_pkg::side_t'(side);
			best_row_q = row_q;
			best_col_q = c + 1;
		end
		r.cell_side = lesf_pkg::side_t'(side);
		r.best_side = best_side_q;
		r.best_row = lesf_pkg::row_t'(best_row_q);
		r.best_column = lesf_pkg::side_t'(best_col_q);
		col_q = c + 1;
		if (col_q >= w)
			next_line();
		return r;
	endfunction

	task automatic check_field(input string name, input logic [12:0] want,
			input logic [12:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	// results are scored before the same edge's transfer is predicted
	always @(posedge clk) begin : scoreboard
		lesf_pkg::out_item_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_squares.size() == 0) begin
				$display("%0t ns: expected no result, actual %p", $time, out_data);
				error_count++;
			end else begin
				want = expected_squares.pop_front();
				check_field("cell_side", want.cell_side, out_data.cell_side);
				check_field("best_side", want.best_side, out_data.best_side);
				check_field("best_row", want.best_row, out_data.best_row);
				check_field("best_column", want.best_column, out_data.best_column);
			end
		end
		if (cfg_wr_en) begin
			case (cfg_index)
				lesf_pkg::REG_EMPTY_CHAR: empty_char_q = int'(cfg_data[7:0]);
				lesf_pkg::REG_ROW_WIDTH:  row_width_q = int'(cfg_data);
				default: ;
			endcase
		end
		if (in_valid && in_ready)
			expected_squares.push_back(compute_square(in_data));
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	task automatic send_cell(input lesf_pkg::byte_t value, input bit first);
		lesf_pkg::in_item_t item;
		item.cell_byte = value;
		item.first_cell = first;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_data <= item;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_row(input string cells, input bit first);
		for (int i = 0; i < cells.len(); i++)
			send_cell(cells[i], first && i == 0);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_squares.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input lesf_pkg::cfg_idx_t idx, input int value);
		cfg_index <= idx;
		cfg_data <= lesf_pkg::cfg_data_t'(value);
		cfg_wr_en <= 1'b1;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// reset registers: width 5, '.' free
	task automatic test_reset_grid();
		send_idle_pct = 13;
		stall_pct = 13;
		send_row(".....", 1'b0);
		send_row(".#...", 1'b0);
		send_row("...#.", 1'b0);
		send_cell(8'h00, 1'b0);
		send_cell(8'hFF, 1'b0);
	endtask

	task automatic test_byte_extremes();
		send_idle_pct = 67;
		stall_pct = 0;
		settle();
		write_reg(lesf_pkg::REG_EMPTY_CHAR, 8'h00);
		write_reg(lesf_pkg::REG_ROW_WIDTH, 0);
		send_cell(8'h00, 1'b1);
		send_cell(8'h00, 1'b0);
		send_cell(8'hFF, 1'b0);
		send_cell(8'h00, 1'b0);
		settle();
		write_reg(lesf_pkg::REG_EMPTY_CHAR, 8'hFF);
		write_reg(lesf_pkg::REG_ROW_WIDTH, 2);
		send_cell(8'hFF, 1'b1);
		repeat (3) send_cell(8'hFF, 1'b0);
		send_cell(8'h00, 1'b0);
		send_cell(8'hFF, 1'b0);
	endtask

	task automatic test_width_change_mid_grid();
		send_idle_pct = 0;
		stall_pct = 67;
		settle();
		write_reg(lesf_pkg::REG_EMPTY_CHAR, FREE);
		write_reg(lesf_pkg::REG_ROW_WIDTH, 4);
		send_row("....", 1'b1);
		send_row("..", 1'b0);
		settle();
		// column already past the new width: row wraps before the next cell
		write_reg(lesf_pkg::REG_ROW_WIDTH, 2);
		send_row("....", 1'b0);
		settle();
		write_reg(lesf_pkg::REG_ROW_WIDTH, 4);
		send_row("........", 1'b0);
	endtask

	task automatic test_tie_keeps_earliest();
		send_idle_pct = 0;
		stall_pct = 0;
		send_row("..#.", 1'b1);
		send_row("..##", 1'b0);
		send_row("#...", 1'b0);
		send_row("#...", 1'b0);
	endtask

	task automatic test_widest_row();
		send_idle_pct = 0;
		stall_pct = 13;
		settle();
		write_reg(lesf_pkg::REG_ROW_WIDTH, 11'h7FF);
		for (int i = 0; i < 48; i++)
			send_cell(($urandom_range(99) < 5) ? BLOCK : FREE, i == 0);
		settle();
		write_reg(lesf_pkg::REG_ROW_WIDTH, MAX_W);
		repeat (8) send_cell(FREE, 1'b0);
	endtask

	task automatic test_random_grids();
		int              sent;
		int              w;
		int              eff;
		int              n;
		int              free_pct;
		bit              need_first;
		bit              broken;
		bit              first;
		lesf_pkg::byte_t empty;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 67;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 67;
				end
				default: begin
					send_idle_pct = 13;
					stall_pct = 13;
				end
			endcase
			settle();
			empty = lesf_pkg::byte_t'($urandom_range(255));
			case ($urandom_range(11))
				0: w = 0;
				1: w = 11'h7FF;
				2: w = $urandom_range(11, MAX_W);
				default: w = $urandom_range(1, 10);
			endcase
			write_reg(lesf_pkg::REG_EMPTY_CHAR, empty);
			write_reg(lesf_pkg::REG_ROW_WIDTH, w);
			eff = eff_width(w);
			// a wider row must not reach line buffer entries never written
			need_first = eff > written_ext;
			sent = 0;
			while (sent < 140) begin
				broken = ($urandom_range(9) == 0);
				n = broken ? $urandom_range(1, 3 * eff) : eff * $urandom_range(1, 6);
				if (n > 40)
					n = 40;
				free_pct = $urandom_range(50, 95);
				for (int i = 0; i < n; i++) begin
					if (i == 0)
						first = need_first || !broken || $urandom_range(1);
					else
						first = broken && $urandom_range(19) == 0;
					send_cell(($urandom_range(99) < free_pct) ? empty :
						lesf_pkg::byte_t'($urandom_range(255)), first);
					need_first = 1'b0;
				end
				sent += n;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = lesf_pkg::REG_EMPTY_CHAR;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_grid();
		test_byte_extremes();
		test_width_change_mid_grid();
		test_tie_keeps_earliest();
		test_widest_row();
		test_random_grids();
		settle();
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("%0t ns: timeout, %0d results outstanding", $time, expected_squares.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
